@@ hw/rtl/fl32_pkg.sv @@
// ============================================================================
// Fletcher-32 checksum package
// Widths, reset values and default sizes shared by the checksum unit and its
// channel interfaces.
// ============================================================================
package fl32_pkg;

   localparam int unsigned WORD_W       = 16;
   localparam int unsigned CHECKSUM_W   = 32;
   localparam int unsigned HALF_W       = 16;
   localparam int unsigned FIRST_SUM_W  = 26;
   localparam int unsigned SECOND_SUM_W = 34;

   localparam int unsigned DEFAULT_FOLD_BLOCK_WORDS = 360;

   localparam logic [HALF_W-1:0] SUM_INIT = 16'hFFFF;

endpackage

@@ hw/rtl/fl32_if.sv @@
// ============================================================================
// Fletcher-32 checksum channel interfaces
// Valid/ready channels for the message words and for the checksums.
// ============================================================================
interface fl32_req_if import fl32_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              is_last;
   logic              no_words;

   modport source (output valid, word, is_last, no_words, input ready);
   modport sink   (input valid, word, is_last, no_words, output ready);

endinterface

interface fl32_rsp_if import fl32_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [CHECKSUM_W-1:0] checksum;

   modport source (output valid, checksum, input ready);
   modport sink   (input valid, checksum, output ready);

endinterface

@@ hw/rtl/fletcher32_checksum_unit.sv @@
// ============================================================================
// Fletcher-32 checksum unit
// Running Fletcher-32 style checksum over a stream of 16-bit words, with a
// fold of both sums after every block of words and two folds at the end.
// ============================================================================
//
//   Channel   Direction   Payload                       Transfer when
//   req_if    in          word, is_last, no_words       valid && ready
//   rsp_if    out         checksum                      valid && ready
//
// One word is taken per clock cycle unless a stalled result holds back the
// input register. rsp_if.valid rises once the last word (or an empty-message
// item) has passed the input register, the fold register and the output
// register. The sum update (two adds and a fold) is combinational, so the
// state loop sustains one word per cycle. Reset is synchronous and returns
// both sums to 0xFFFF and the block counter to zero. A stalled result only
// holds back words once the fold and output registers are both full; words
// that close no message keep flowing while a checksum waits.
//
module fletcher32_checksum_unit import fl32_pkg::*; #(
   parameter int unsigned FOLD_BLOCK_WORDS = DEFAULT_FOLD_BLOCK_WORDS
) (
   input  logic        clock,
   input  logic        reset,
   fl32_req_if.sink    req_if,
   fl32_rsp_if.source  rsp_if
);

   // The block counter only needs to reach the block size itself.
   localparam int unsigned CNT_W = $clog2(FOLD_BLOCK_WORDS + 1);
   localparam logic [CNT_W-1:0] BLOCK_WORDS = CNT_W'(FOLD_BLOCK_WORDS);

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
      logic              is_last;
      logic              no_words;
   } in_stage_type;

   typedef struct packed {
      logic                    valid;
      logic [FIRST_SUM_W-1:0]  first;
      logic [SECOND_SUM_W-1:0] second;
   } fold_stage_type;

   // Adds the bits above the low half back into the low half.
   function automatic logic [FIRST_SUM_W-1:0] fold_first(input logic [FIRST_SUM_W-1:0] x);
      return FIRST_SUM_W'(x[HALF_W-1:0]) + FIRST_SUM_W'(x[FIRST_SUM_W-1:HALF_W]);
   endfunction

   function automatic logic [SECOND_SUM_W-1:0] fold_second(
      input logic [SECOND_SUM_W-1:0] x);
      return SECOND_SUM_W'(x[HALF_W-1:0]) + SECOND_SUM_W'(x[SECOND_SUM_W-1:HALF_W]);
   endfunction

   in_stage_type            a_ff, a_in;
   fold_stage_type          b_ff, b_in;
   logic                    c_valid_ff, c_valid_in;
   logic [CHECKSUM_W-1:0]   checksum_ff, checksum_in;

   logic [FIRST_SUM_W-1:0]  first_sum_ff, first_sum_in;
   logic [SECOND_SUM_W-1:0] second_sum_ff, second_sum_in;
   logic [CNT_W-1:0]        words_ff, words_in;

   logic                    a_has_result, a_ready, a_fire;
   logic                    b_ready, c_ready;
   logic [FIRST_SUM_W-1:0]  first_add, first_folded, first_final;
   logic [SECOND_SUM_W-1:0] second_add, second_folded, second_final;
   logic [CNT_W-1:0]        words_inc;
   logic                    do_fold;

   // ------------------------------------------------------------------------
   // Handshake. Each stage takes a new entry when it is empty or when its own
   // entry moves on in the same cycle. Words that close no message leave the
   // input register without needing room further down.
   // ------------------------------------------------------------------------
   assign c_ready      = !c_valid_ff || rsp_if.ready;
   assign b_ready      = !b_ff.valid || c_ready;
   assign a_has_result = a_ff.is_last || a_ff.no_words;
   assign a_ready      = !a_ff.valid || !a_has_result || b_ready;
   assign a_fire       = a_ff.valid && a_ready;

   assign req_if.ready    = a_ready;
   assign rsp_if.valid    = c_valid_ff;
   assign rsp_if.checksum = checksum_ff;

   // Input register.
   always_comb begin
      a_in = a_ff;
      if (a_fire) begin
         a_in.valid = 1'b0;
      end
      if (req_if.valid && a_ready) begin
         a_in.valid    = 1'b1;
         a_in.word     = req_if.word;
         a_in.is_last  = req_if.is_last;
         a_in.no_words = req_if.no_words;
      end
   end

   // ------------------------------------------------------------------------
   // Sum update. The word goes into the first sum, the new first sum into the
   // second, and both are folded when a block completes or the message ends.
   // ------------------------------------------------------------------------
   assign first_add     = first_sum_ff + FIRST_SUM_W'(a_ff.word);
   assign second_add    = second_sum_ff + SECOND_SUM_W'(first_add);
   assign words_inc     = words_ff + CNT_W'(1);
   assign do_fold       = (words_inc >= BLOCK_WORDS) || a_ff.is_last;
   assign first_folded  = fold_first(first_add);
   assign second_folded = fold_second(second_add);

   always_comb begin
      first_sum_in  = first_sum_ff;
      second_sum_in = second_sum_ff;
      words_in      = words_ff;
      if (a_fire) begin
         if (a_has_result) begin
            // The message is complete or empty: the sums start afresh.
            first_sum_in  = FIRST_SUM_W'(SUM_INIT);
            second_sum_in = SECOND_SUM_W'(SUM_INIT);
            words_in      = '0;
         end else if (do_fold) begin
            first_sum_in  = first_folded;
            second_sum_in = second_folded;
            words_in      = '0;
         end else begin
            first_sum_in  = first_add;
            second_sum_in = second_add;
            words_in      = words_inc;
         end
      end
   end

   // Fold register. An empty message enters with both sums at their initial
   // value, which the final fold leaves unchanged, giving all ones.
   always_comb begin
      b_in = b_ff;
      if (b_ff.valid && c_ready) begin
         b_in.valid = 1'b0;
      end
      if (a_fire && a_has_result) begin
         b_in.valid = 1'b1;
         if (a_ff.no_words) begin
            b_in.first  = FIRST_SUM_W'(SUM_INIT);
            b_in.second = SECOND_SUM_W'(SUM_INIT);
         end else begin
            b_in.first  = first_folded;
            b_in.second = second_folded;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Final fold and output register. The second sum is shifted into the upper
   // half and ORed with the whole first sum, truncated to the checksum width.
   // ------------------------------------------------------------------------
   assign first_final  = fold_first(b_ff.first);
   assign second_final = fold_second(b_ff.second);

   always_comb begin
      c_valid_in  = c_valid_ff;
      checksum_in = checksum_ff;
      if (c_valid_ff && rsp_if.ready) begin
         c_valid_in = 1'b0;
      end
      if (b_ff.valid && c_ready) begin
         c_valid_in  = 1'b1;
         checksum_in = {second_final[HALF_W-1:0], HALF_W'(0)}
                     | CHECKSUM_W'(first_final);
      end
   end

   always_ff @(posedge clock) begin
      checksum_ff <= checksum_in;
      if (reset) begin
         a_ff          <= '0;
         b_ff          <= '0;
         c_valid_ff    <= 1'b0;
         first_sum_ff  <= FIRST_SUM_W'(SUM_INIT);
         second_sum_ff <= SECOND_SUM_W'(SUM_INIT);
         words_ff      <= '0;
      end else begin
         a_ff          <= a_in;
         b_ff          <= b_in;
         c_valid_ff    <= c_valid_in;
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
         words_ff      <= words_in;
      end
   end

`ifndef SYNTH
   // The block counter never reaches the block size; it clears on the fold.
   assert property (@(posedge clock) disable iff (reset)
      words_ff < BLOCK_WORDS)
      else $error("block word counter reached the block size");

   // A message end or an empty message leaves the sums at their initial value.
   assert property (@(posedge clock) disable iff (reset)
      (a_fire && a_has_result) |=> (first_sum_ff == FIRST_SUM_W'(SUM_INIT)
                                    && second_sum_ff == SECOND_SUM_W'(SUM_INIT)
                                    && words_ff == '0))
      else $error("sums not restarted after a message end");

   // An entry in the fold register that finds room reaches the output register.
   assert property (@(posedge clock) disable iff (reset)
      (b_ff.valid && c_ready) |=> c_valid_ff)
      else $error("folded sums lost on the way to the output register");
`endif

endmodule

@@ tb/fletcher32_checksum_unit_tb.sv @@
// ============================================================================
// Fletcher-32 checksum unit testbench
// Drives message words into the unit with random gaps and result stalls,
// predicts every checksum from an independent model of the running sums and
// their fold schedule, and checks each result transfer in order.
// ============================================================================
module fletcher32_checksum_unit_tb;
   import fl32_pkg::*;

   // The unit is built with its default block size, so the fold schedule
   // here has to match that size exactly.
   localparam int unsigned FOLD_WORDS       = DEFAULT_FOLD_BLOCK_WORDS;
   localparam int unsigned RANDOM_ITEMS     = 120;
   localparam int unsigned CALM_ITEMS       = 30;
   localparam int unsigned HOLD_START_ITEMS = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 250;
   localparam int unsigned HOLD_MESSAGES    = 40;
   localparam int unsigned DRAIN_CYCLES     = 16;

   localparam logic [CHECKSUM_W-1:0] EMPTY_CHECKSUM = 32'hFFFF_FFFF;

   // One row of stimulus. Where the checksum can be read off by hand it is
   // pinned in the row and takes precedence over the predictor.
   typedef struct packed {
      logic [WORD_W-1:0]     word;
      logic                  is_last;
      logic                  no_words;
      logic                  pinned;
      logic [CHECKSUM_W-1:0] pinned_sum;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fl32_req_if req_if ();
   fl32_rsp_if rsp_if ();

   fletcher32_checksum_unit #(
      .FOLD_BLOCK_WORDS (FOLD_WORDS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop. The slowest legal run is well under a tenth of this.
   initial begin
      #5_000_000;
      $display("fletcher32_checksum_unit verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Running-sum model
   // ------------------------------------------------------------------------
   // The sums are kept at the same widths as in the unit. A fold adds the
   // bits above bit 15 back into the low half; after the final fold the
   // first sum fits in the low 16 bits, so it never overlaps the shifted
   // second sum and the OR that forms the result acts as a concatenation.
   logic [FIRST_SUM_W-1:0]  model_first;
   logic [SECOND_SUM_W-1:0] model_second;
   logic [8:0]              words_since_fold;

   stim_row_type            pending_rows[$];
   logic [CHECKSUM_W-1:0]   expected_checksums[$];
   int unsigned             mismatch_count = 0;

   bit                      calm_phase = 1'b0;
   bit                      long_hold_pending = 1'b0;

   function automatic void clear_sums();
      model_first      = FIRST_SUM_W'(SUM_INIT);
      model_second     = SECOND_SUM_W'(SUM_INIT);
      words_since_fold = '0;
   endfunction

   function automatic logic [63:0] fold_carries(logic [63:0] x);
      return {48'd0, x[15:0]} + (x >> 16);
   endfunction

   function automatic void fold_sums();
      logic [63:0] folded_first;
      logic [63:0] folded_second;
      folded_first  = fold_carries(64'(model_first));
      folded_second = fold_carries(64'(model_second));
      model_first   = folded_first[FIRST_SUM_W-1:0];
      model_second  = folded_second[SECOND_SUM_W-1:0];
   endfunction

   // Advances the sums by one accepted item and reports whether that item
   // closes a message, and with which checksum.
   function automatic void advance_fletcher(
      input  logic [WORD_W-1:0]     word,
      input  logic                  is_last,
      input  logic                  no_words,
      output logic                  produced,
      output logic [CHECKSUM_W-1:0] checksum
   );
      logic [63:0] sum;
      produced = 1'b0;
      checksum = '0;
      if (no_words) begin
         // An empty message also throws away any unfinished one.
         clear_sums();
         produced = 1'b1;
         checksum = EMPTY_CHECKSUM;
      end else begin
         sum          = 64'(model_first) + 64'(word);
         model_first  = sum[FIRST_SUM_W-1:0];
         sum          = 64'(model_second) + 64'(model_first);
         model_second = sum[SECOND_SUM_W-1:0];
         words_since_fold = words_since_fold + 9'd1;
         // A last word that also completes a block gets a single block fold.
         if (words_since_fold >= FOLD_WORDS || is_last) begin
            fold_sums();
            words_since_fold = '0;
         end
         if (is_last) begin
            fold_sums();
            sum      = (64'(model_second) << 16) | 64'(model_first);
            checksum = sum[CHECKSUM_W-1:0];
            produced = 1'b1;
            clear_sums();
         end
      end
   endfunction

   task automatic report_mismatch(
      input string                 what,
      input logic [CHECKSUM_W-1:0] got,
      input logic [CHECKSUM_W-1:0] want
   );
      mismatch_count++;
      $display("[%0t] checksum mismatch (%s): got %08h, expected %08h", $realtime, what,
               got, want);
   endtask

   // ------------------------------------------------------------------------
   // Monitors
   // ------------------------------------------------------------------------
   // Every input transfer advances the model. Both monitors sample at the
   // rising edge, so they see the values that were present before any
   // update made at that edge.
   always @(posedge clock) begin : input_monitor
      stim_row_type          row;
      logic                  produced;
      logic [CHECKSUM_W-1:0] checksum;
      if (reset) begin
         clear_sums();
      end else if (req_if.valid && req_if.ready) begin
         row = pending_rows.pop_front();
         advance_fletcher(req_if.word, req_if.is_last, req_if.no_words, produced, checksum);
         if (produced) begin
            expected_checksums.push_back(row.pinned ? row.pinned_sum : checksum);
         end
      end
   end

   // Each result transfer is matched against the oldest outstanding checksum.
   always @(posedge clock) begin : result_monitor
      logic [CHECKSUM_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_checksums.size() == 0) begin
            report_mismatch("no checksum outstanding", rsp_if.checksum, '0);
         end else begin
            want = expected_checksums.pop_front();
            if (rsp_if.checksum !== want) begin
               report_mismatch("checksum field", rsp_if.checksum, want);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   // Ready is mostly high, with random stall bursts. Once, on request from
   // the stimulus, it is held low for a long stretch so that the unit's
   // output and fold registers fill and it has to refuse words.
   initial begin
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_pending = 1'b0;
            rsp_if.ready <= 1'b1;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   // Directed rows. The pinned checksums follow directly from the sums
   // starting at 0xFFFF: a lone zero or a lone 0xFFFF folds back to all
   // ones, and a lone one leaves 1 in both halves.
   stim_row_type directed_rows [0:18] = '{
      // Empty message straight after reset.
      '{16'h0000, 1'b0, 1'b1, 1'b1, EMPTY_CHECKSUM},
      // Single-word messages at the extremes of the word.
      '{16'h0000, 1'b1, 1'b0, 1'b1, EMPTY_CHECKSUM},
      '{16'hFFFF, 1'b1, 1'b0, 1'b1, EMPTY_CHECKSUM},
      '{16'h0001, 1'b1, 1'b0, 1'b1, 32'h0001_0001},
      // The empty flag wins over the last flag and the word.
      '{16'hFFFF, 1'b1, 1'b1, 1'b1, EMPTY_CHECKSUM},
      // Two-word message across the top bit.
      '{16'h8000, 1'b0, 1'b0, 1'b0, '0},
      '{16'h7FFF, 1'b1, 1'b0, 1'b0, '0},
      // An unfinished message abandoned by an empty one.
      '{16'h1234, 1'b0, 1'b0, 1'b0, '0},
      '{16'hABCD, 1'b0, 1'b0, 1'b0, '0},
      '{16'h5A5A, 1'b0, 1'b1, 1'b1, EMPTY_CHECKSUM},
      // All ones, then all zeros, over several words.
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1'b0, 1'b0, '0},
      '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
      '{16'h0000, 1'b1, 1'b0, 1'b0, '0},
      // Alternating bit patterns, then a lone 0xFFFE.
      '{16'hAAAA, 1'b0, 1'b0, 1'b0, '0},
      '{16'h5555, 1'b1, 1'b0, 1'b0, '0},
      '{16'hFFFE, 1'b1, 1'b0, 1'b0, '0},
      // A second empty message after normal traffic.
      '{16'hC3C3, 1'b0, 1'b1, 1'b1, EMPTY_CHECKSUM}
   };

   function automatic stim_row_type make_row(logic [WORD_W-1:0] word, logic is_last,
                                             logic no_words);
      stim_row_type row;
      row.word       = word;
      row.is_last    = is_last;
      row.no_words   = no_words;
      row.pinned     = 1'b0;
      row.pinned_sum = '0;
      return row;
   endfunction

   // Random words lean towards the extremes so that the sums carry often.
   function automatic logic [WORD_W-1:0] pick_word();
      int unsigned choice;
      choice = $urandom_range(0, 7);
      if (choice == 0) return '1;
      if (choice == 1) return '0;
      return WORD_W'($urandom);
   endfunction

   // Offers one item and waits for its transfer. A random gap may come first;
   // valid is only changed once per clock edge.
   task automatic send_item(input stim_row_type row);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      pending_rows.push_back(row);
      req_if.valid    <= 1'b1;
      req_if.word     <= row.word;
      req_if.is_last  <= row.is_last;
      req_if.no_words <= row.no_words;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_message(input int unsigned length, input bit all_ones);
      for (int unsigned n = 0; n < length; n++) begin
         send_item(make_row(all_ones ? '1 : pick_word(), n == length - 1, 1'b0));
      end
   endtask

   initial begin
      int unsigned random_items;
      int unsigned length;
      int unsigned kind;
      bit          hold_done;

      random_items = 0;
      hold_done    = 1'b0;

      req_if.valid    = 1'b0;
      req_if.word     = '0;
      req_if.is_last  = 1'b0;
      req_if.no_words = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
      end

      // One long message past the block fold, every word at its maximum
      // (the worst case for sum headroom): the sums fold on a word that is
      // not the last, and the message then ends just after the boundary.
      send_message(FOLD_WORDS + 1, 1'b1);

      // Random traffic: mostly well-formed messages of random length and
      // content, with some stray empty items and abandoned messages.
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) calm_phase = 1'b1;

         if (!hold_done && random_items >= HOLD_START_ITEMS) begin
            // Keep offering short messages while the result side is held off,
            // so that checksums pile up and the input has to stall.
            hold_done         = 1'b1;
            long_hold_pending = 1'b1;
            repeat (HOLD_MESSAGES) send_message(1, 1'b0);
            random_items += HOLD_MESSAGES;
         end else begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
               send_item(make_row(WORD_W'($urandom), 1'($urandom), 1'b1));
               random_items += 1;
            end else if (kind == 1) begin
               length = $urandom_range(1, 6);
               for (int unsigned n = 0; n < length; n++) begin
                  send_item(make_row(pick_word(), 1'b0, 1'b0));
               end
               send_item(make_row(pick_word(), 1'($urandom), 1'b1));
               random_items += length + 1;
            end else begin
               length = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
               send_message(length, 1'b0);
               random_items += length;
            end
         end
      end

      req_if.valid <= 1'b0;

      // Let every outstanding checksum arrive, then wait out a drain period
      // in which any surplus result would show up.
      while (expected_checksums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("fletcher32_checksum_unit verification clean");
      end else begin
         $display("fletcher32_checksum_unit verification failed");
      end
      $finish;
   end

endmodule
